/* rtl/core/nqsa_pkg.sv */
// Shared constants for the GF(2^m) syndrome accumulator.
package nqsa_pkg;

    // Field size m and the derived GF(2^m) constants.
    localparam int GF_BITS  = 4;
    localparam int GF_SIZE  = 1 << GF_BITS;
    localparam int GF_ORDER = GF_SIZE - 1;
    localparam int SUM_W    = GF_BITS + 1;

    // Stream payload widths.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Operation codes carried in s_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TERM = 1'b1;

endpackage

/* rtl/core/nonbinary_quantum_syndrome_accumulator.sv */
// Top level of the GF(2^m) symplectic syndrome accumulator.
//
// The block takes one beat per cycle on the slave stream: a load beat writes one
// entry of the antilog table, and a term beat forms stabX*errZ + stabZ*errX for
// one check-row entry in the log domain, looks both products up in the table and
// XORs them into the row accumulator. A term beat with tlast set delivers the
// row's syndrome on the master stream and clears the accumulator. Each beat passes
// the term stage (the log-domain adds and the two table reads, from a 16-entry
// memory with two registered read ports), then the accumulate stage, which hands a
// finished row to the master side's own output register. The block accepts one beat
// every cycle except while a finished row waits behind an unaccepted syndrome, which
// stalls the input. The table has no reset and must be loaded before use, entry 0
// with the zero polynomial.
module nonbinary_quantum_syndrome_accumulator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0 up: table_index[3:0], table_word[7:4],
    // stab_code[15:8], error_code[23:16].
    input  logic [nqsa_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: op[0].
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0 up: syndrome[3:0], zero fill above.
    output logic [nqsa_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int GB = nqsa_pkg::GF_BITS;

    // Log-domain product of two log codes; zero if either factor is zero.
    function automatic logic [nqsa_pkg::GF_BITS-1:0] log_mul(
        input logic [nqsa_pkg::GF_BITS-1:0] a,
        input logic [nqsa_pkg::GF_BITS-1:0] b
    );
        logic [nqsa_pkg::SUM_W-1:0] s;
        logic [nqsa_pkg::SUM_W-1:0] r;
        s = {1'b0, a} + {1'b0, b} - nqsa_pkg::SUM_W'(1);
        if (s > nqsa_pkg::SUM_W'(nqsa_pkg::GF_ORDER)) begin
            r = s - nqsa_pkg::SUM_W'(nqsa_pkg::GF_ORDER);
        end else begin
            r = s;
        end
        if (a == '0 || b == '0) begin
            log_mul = '0;
        end else begin
            log_mul = r[nqsa_pkg::GF_BITS-1:0];
        end
    endfunction

    // Input field unpacking.
    logic          op;
    logic [GB-1:0] table_index;
    logic [GB-1:0] table_word;
    logic [GB-1:0] sx, sz, ex, ez;
    logic [GB-1:0] pa, pb;
    logic          err_nonzero;
    logic          accept;
    logic          advance;

    assign op          = s_tuser;
    assign table_index = s_tdata[GB-1:0];
    assign table_word  = s_tdata[4+GB-1:4];
    assign sx          = s_tdata[8+2*GB-1:8+GB];
    assign sz          = s_tdata[8+GB-1:8];
    assign ex          = s_tdata[16+2*GB-1:16+GB];
    assign ez          = s_tdata[16+GB-1:16];
    assign err_nonzero = (ex != '0) || (ez != '0);
    assign pa          = log_mul(sx, ez);
    assign pb          = log_mul(sz, ex);

    // Stage and output registers.
    logic          v1_reg, v1_next;
    logic          active1_reg;
    logic          last1_reg;
    logic [GB-1:0] rda_reg, rdb_reg;
    logic [GB-1:0] acc_reg, acc_next;
    logic [GB-1:0] acc_sum;
    logic          m_valid_reg, m_valid_next;
    logic [GB-1:0] syn_reg;

    logic [GB-1:0] antilog_mem [nqsa_pkg::GF_SIZE];

    // The term stage moves on unless it holds a finished row that cannot be handed over.
    assign advance  = !v1_reg || !last1_reg || !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && s_tready;

    // Antilog table: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (accept && op == nqsa_pkg::OP_LOAD) begin
            antilog_mem[table_index] <= table_word;
        end
        if (accept && op == nqsa_pkg::OP_TERM) begin
            rda_reg <= antilog_mem[pa];
            rdb_reg <= antilog_mem[pb];
        end
    end

    // Term side information held alongside the read data.
    always_ff @(posedge aclk) begin
        if (accept) begin
            active1_reg <= err_nonzero;
            last1_reg   <= s_tlast;
        end
    end

    // Accumulate and hand finished rows to the output register.
    always_comb begin
        acc_sum      = active1_reg ? (acc_reg ^ rda_reg ^ rdb_reg) : acc_reg;
        acc_next     = acc_reg;
        v1_next      = v1_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (v1_reg && advance) begin
            acc_next = last1_reg ? '0 : acc_sum;
            if (last1_reg) begin
                m_valid_next = 1'b1;
            end
        end
        if (advance) begin
            v1_next = accept && (op == nqsa_pkg::OP_TERM);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && advance && last1_reg) begin
            syn_reg <= acc_sum;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(nqsa_pkg::M_TDATA_W - GB){1'b0}}, syn_reg};

    // A last term beat reaches the accumulate stage in the next cycle.
    a_last_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == nqsa_pkg::OP_TERM && s_tlast) |=> (v1_reg && last1_reg))
        else $error("last term beat did not enter the accumulate stage");

    // A finished row blocked behind an unaccepted syndrome stalls the input.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && last1_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while a finished row was blocked");

    // Retiring a row leaves the accumulator clear.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && last1_reg && advance) |=> (acc_reg == '0))
        else $error("accumulator not cleared after a row");

    // A syndrome only appears after a last term left the accumulate stage.
    a_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v1_reg && last1_reg))
        else $error("syndrome emitted without a finished row");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the GF(2^m) syndrome accumulator with a row-syndrome predictor.

// Predicts row syndromes from the accepted beats and checks the emitted ones in order.
class row_syndrome_ledger;
    typedef logic [nqsa_pkg::GF_BITS-1:0] gf_word_t;

    gf_word_t antilog_words [nqsa_pkg::GF_SIZE];
    gf_word_t row_sum;
    gf_word_t due_syndromes [$];
    int       mismatches;

    function new();
        row_sum    = '0;
        mismatches = 0;
        foreach (antilog_words[i]) antilog_words[i] = '0;
    endfunction

    // Product of two log codes: exponents add modulo 2^m-1, a zero factor gives code zero.
    function gf_word_t log_product(gf_word_t a, gf_word_t b);
        int exp_sum;
        if (a == 0 || b == 0) return '0;
        exp_sum = int'(a) + int'(b) - 2;
        if (exp_sum >= nqsa_pkg::GF_ORDER) exp_sum -= nqsa_pkg::GF_ORDER;
        return gf_word_t'(exp_sum + 1);
    endfunction

    // Applies one accepted slave beat to the predicted table and row sum.
    function void absorb_beat(logic op, logic [nqsa_pkg::S_TDATA_W-1:0] data, logic last);
        gf_word_t stab_x, stab_z, err_x, err_z;
        if (op == nqsa_pkg::OP_LOAD) begin
            antilog_words[data[3:0]] = data[7:4];
            return;
        end
        stab_x = data[15:12];
        stab_z = data[11:8];
        err_x  = data[23:20];
        err_z  = data[19:16];
        // A zero error symbol leaves the row untouched.
        if (err_x != 0 || err_z != 0) begin
            row_sum = row_sum ^ antilog_words[log_product(stab_x, err_z)]
                              ^ antilog_words[log_product(stab_z, err_x)];
        end
        if (last) begin
            due_syndromes.push_back(row_sum);
            row_sum = '0;
        end
    endfunction

    // Compares one master beat with the oldest predicted syndrome.
    function void check_syndrome(logic [nqsa_pkg::M_TDATA_W-1:0] data);
        gf_word_t got, want;
        got = data[nqsa_pkg::GF_BITS-1:0];
        if (due_syndromes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected syndrome %h with no row pending", got);
            return;
        end
        want = due_syndromes.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("syndrome mismatch: expected %h, got %h", want, got);
        end
    endfunction

    function int pending();
        return due_syndromes.size();
    endfunction
endclass

module tb_top;
    localparam int STUCK_LIMIT = 4000;

    logic                           aclk;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [nqsa_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = nqsa_pkg::OP_LOAD;
    logic                           s_tlast  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [nqsa_pkg::M_TDATA_W-1:0] m_tdata;

    row_syndrome_ledger ledger = new();

    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int rx_hold_request = 0;
    int beats_sent      = 0;
    int stuck_cycles    = 0;

    nonbinary_quantum_syndrome_accumulator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Both streams are observed at the same edge; inputs are absorbed before results are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) ledger.absorb_beat(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) ledger.check_syndrome(m_tdata);
        end
    end

    // Ends the run if neither stream moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("nonbinary_quantum_syndrome_accumulator regression: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offers one beat after an optional random gap and waits for its handshake.
    task automatic send_beat(logic op, logic [nqsa_pkg::S_TDATA_W-1:0] data, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // Table write; the unused fields and tlast carry noise.
    task automatic send_load(logic [3:0] index, logic [3:0] word);
        send_beat(nqsa_pkg::OP_LOAD, {16'($urandom), word, index}, 1'($urandom));
    endtask

    // Check-row term; the table fields carry noise.
    task automatic send_term(logic [7:0] stab, logic [7:0] err, logic last);
        send_beat(nqsa_pkg::OP_TERM, {err, stab, 8'($urandom)}, last);
    endtask

    // Stops offering and waits until every predicted syndrome has arrived.
    task automatic drain_rows();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    // Random rows of one to six terms, with table rewrites mixed in.
    task automatic run_rows(int beat_count);
        int         stop_at;
        int         row_len;
        logic [3:0] index;
        logic [7:0] err;
        stop_at = beats_sent + beat_count;
        while (beats_sent < stop_at) begin
            row_len = $urandom_range(1, 6);
            for (int t = 0; t < row_len; t++) begin
                if ($urandom_range(9) == 0) begin
                    // Entry 0 stays the zero polynomial.
                    index = 4'($urandom_range(15));
                    send_load(index, (index == 0) ? 4'h0 : 4'($urandom_range(15)));
                end
                err = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom);
                send_term(8'($urandom), err, t == row_len - 1);
            end
        end
    endtask

    initial begin
        logic [3:0] poly;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct  = 35;
        rx_stall_pct = 56;

        // Full antilog table for x^4 + x + 1, entry 0 as the zero polynomial.
        send_load(4'd0, 4'h0);
        poly = 4'h1;
        for (int k = 1; k < nqsa_pkg::GF_SIZE; k++) begin
            send_load(4'(k), poly);
            poly = {poly[2:0], 1'b0} ^ (poly[3] ? 4'b0011 : 4'b0000);
        end

        // Directed terms: widest exponent wrap, zero factors, zero error on a last term,
        // a table rewrite between rows, and mixed codes.
        send_term(8'hFF, 8'hFF, 1'b0);
        send_term(8'h00, 8'hFF, 1'b1);
        send_term(8'hFF, 8'h00, 1'b1);
        send_term(8'h11, 8'h11, 1'b0);
        send_term(8'hF1, 8'h1F, 1'b0);
        send_term(8'h0F, 8'hF0, 1'b1);
        send_load(4'd5, 4'hA);
        send_term(8'h5A, 8'hA5, 1'b1);
        send_term(8'h80, 8'h08, 1'b1);
        drain_rows();

        run_rows(460);
        drain_rows();

        tx_idle_pct  = 56;
        rx_stall_pct = 35;
        run_rows(460);
        drain_rows();

        // No idling, but the receiver first holds off long enough to back up the input.
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        rx_hold_request = 300;
        run_rows(460);
        drain_rows();

        repeat (8) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("nonbinary_quantum_syndrome_accumulator regression: pass");
        end else begin
            $display("nonbinary_quantum_syndrome_accumulator regression: fail");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/nqsa_pkg.sv
rtl/core/nonbinary_quantum_syndrome_accumulator.sv
test/tb_top.sv
